FILE: hw/rtl/tbad_pkg.sv
// ============================================================================
// tbad_pkg: shared types and constants of the time bucket downsampler
// Holds lane layout, the job passed from front to back and the result beat.
// ============================================================================
package tbad_pkg;

    localparam int NUM_LANES = 4;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 16;
    localparam int LANE_W    = SUM_W + CNT_W;
    localparam int IDX_W     = 6;

    localparam logic [15:0]      SAMPLE_MISSING = 16'h8000;
    localparam logic [CNT_W-1:0] CNT_MAX        = 16'hFFFF;

    localparam logic [1:0] REG_RANGE  = 2'd0;
    localparam logic [1:0] REG_POINTS = 2'd1;
    localparam logic [1:0] REG_NOW    = 2'd2;

    typedef logic [NUM_LANES-1:0][15:0] temp_vec_t;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [31:0]      wstart;
        logic [31:0]      bwidth;
        temp_vec_t        temps;
    } job_t;

    typedef struct packed {
        logic [31:0]          btime;
        temp_vec_t            avg;
        logic [NUM_LANES-1:0] mask;
        logic                 last;
    } res_t;

endpackage

FILE: hw/rtl/tbad_ram.sv
// ============================================================================
// tbad_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module tbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/tbad_div.sv
// ============================================================================
// tbad_div: 32 by 32 bit unsigned restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ============================================================================
module tbad_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 5'd31;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[31:0] : shifted[31:0];
            quo_next  = {quo_reg[30:0], fits};
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/tbad_front.sv
// ============================================================================
// tbad_front: record intake and classification
// Derives window start and bucket width, drops records outside the window
// and computes the clamped bucket index before handing a job to the queue.
// ============================================================================
module tbad_front #(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [31:0]         timestamp,
    input  tbad_pkg::temp_vec_t temps,
    input  logic [31:0]         range_seconds,
    input  logic [5:0]          max_points,
    input  logic [31:0]         now_time,
    output logic                push,
    output tbad_pkg::job_t      job,
    input  logic                q_full
);

    import tbad_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_WIDTH = 4'b0010,
        F_INDEX = 4'b0100,
        F_PUSH  = 4'b1000
    } f_state_t;

    localparam logic [IDX_W-1:0] LIM_MAX = IDX_W'(MAX_BUCKETS - 1);

    f_state_t         state_reg, state_next;
    logic             cmd_reg, cmd_next;
    logic [31:0]      ts_reg, ts_next;
    temp_vec_t        temps_reg, temps_next;
    logic [31:0]      ws_reg, ws_next;
    logic [31:0]      bw_reg, bw_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [5:0]       eff_points;
    logic [IDX_W-1:0] lim;
    logic [31:0]      ws_now;
    logic [31:0]      q_bw;
    logic             in_window;
    logic             div_start, div_busy, div_done;
    logic [31:0]      div_dividend, div_divisor, div_q;

    assign eff_points = (max_points == 6'd0) ? 6'd1 : max_points;
    assign lim        = (eff_points > LIM_MAX) ? LIM_MAX : eff_points;
    assign ws_now     = (range_seconds >= now_time) ? 32'd0 : now_time - range_seconds;
    assign q_bw       = (div_q == 32'd0) ? 32'd1 : div_q;
    assign in_window  = (ts_reg >= ws_reg) && (ts_reg <= now_time);

    always_comb
    begin
        if (state_reg == F_IDLE)
        begin
            div_dividend = range_seconds;
            div_divisor  = {26'd0, eff_points};
        end
        else
        begin
            div_dividend = ts_reg - ws_reg;
            div_divisor  = q_bw;
        end
    end

    assign div_start = ((state_reg == F_IDLE) && in_valid) ||
                       ((state_reg == F_WIDTH) && div_done && !cmd_reg && in_window);

    tbad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ts_next    = ts_reg;
        temps_next = temps_reg;
        ws_next    = ws_reg;
        bw_next    = bw_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    ts_next    = timestamp;
                    temps_next = temps;
                    ws_next    = ws_now;
                    state_next = F_WIDTH;
                end
            end
            F_WIDTH:
            begin
                if (div_done)
                begin
                    bw_next = q_bw;
                    if (cmd_reg)
                    begin
                        state_next = F_PUSH;
                    end
                    else if (in_window)
                    begin
                        state_next = F_INDEX;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            F_INDEX:
            begin
                if (div_done)
                begin
                    idx_next   = (div_q > {26'd0, lim}) ? lim : div_q[IDX_W-1:0];
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        ts_reg    <= ts_next;
        temps_reg <= temps_next;
        ws_reg    <= ws_next;
        bw_reg    <= bw_next;
        idx_reg   <= idx_next;
    end

    // The width division can only run while the divider is free.
    assign in_stall = (state_reg != F_IDLE) || div_busy;
    assign push     = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        job.cmd    = cmd_reg;
        job.idx    = idx_reg;
        job.wstart = ws_reg;
        job.bwidth = bw_reg;
        job.temps  = temps_reg;
    end

endmodule

FILE: hw/rtl/tbad_queue.sv
// ============================================================================
// tbad_queue: two-entry job queue between front and back
// Lets the front classify the next record while the back is still busy.
// ============================================================================
module tbad_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tbad_pkg::job_t job_in,
    output logic           full,
    input  logic           pop,
    output tbad_pkg::job_t job_out,
    output logic           empty
);

    import tbad_pkg::*;

    job_t       mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign job_out = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= job_in;
        end
    end

endmodule

FILE: hw/rtl/tbad_back.sv
// ============================================================================
// tbad_back: bucket store update and emit walk
// Performs the read-modify-write of a bucket row per record, and on emit walks
// all rows, divides out rounded averages and clears the store.
// ============================================================================
module tbad_back #(
    parameter int CHANNELS    = 4,
    parameter int MAX_BUCKETS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  tbad_pkg::job_t job_in,
    output logic           pop,
    input  logic           out_stall,
    output logic           out_valid,
    output tbad_pkg::res_t res
);

    import tbad_pkg::*;

    localparam int AW     = $clog2(MAX_BUCKETS);
    localparam int RW     = CHANNELS * LANE_W;
    localparam int FULL_W = NUM_LANES * LANE_W;
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_BUCKETS - 1);

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_ACC  = 8'b0000_0010,
        B_ERD  = 8'b0000_0100,
        B_EWT  = 8'b0000_1000,
        B_EDST = 8'b0001_0000,
        B_EDWT = 8'b0010_0000,
        B_EPUT = 8'b0100_0000,
        B_EEND = 8'b1000_0000
    } b_state_t;

    b_state_t                              state_reg, state_next;
    job_t                                  job_reg, job_next;
    logic [AW-1:0]                         b_reg, b_next;
    logic [31:0]                           time_reg, time_next;
    logic [1:0]                            ch_reg, ch_next;
    logic [NUM_LANES-1:0]                  mask_reg, mask_next;
    logic [NUM_LANES-1:0][SUM_W-1:0]       sums_reg, sums_next;
    logic [NUM_LANES-1:0][CNT_W-1:0]       cnts_reg, cnts_next;
    temp_vec_t                             avg_reg, avg_next;
    res_t                                  pend_reg, pend_next;
    logic                                  pend_vld_reg, pend_vld_next;
    res_t                                  out_reg, out_next;
    logic                                  out_vld_reg, out_vld_next;
    logic [MAX_BUCKETS-1:0]                vld_reg, vld_next;

    logic [AW-1:0]       raddr;
    logic [AW-1:0]       row_addr;
    logic [RW-1:0]       rdata;
    logic [FULL_W-1:0]   row_full;
    logic [FULL_W-1:0]   new_full;
    logic [SUM_W-1:0]    lane_sum;
    logic [CNT_W-1:0]    lane_cnt;
    logic [15:0]         lane_t;
    logic                we;
    logic                out_free;
    logic                div_start, div_busy, div_done;
    logic [31:0]         div_q;
    logic [31:0]         mag;
    logic [31:0]         div_dividend;
    logic [31:0]         div_divisor;
    logic [15:0]         q16;
    res_t                cur;

    assign raddr    = (state_reg == B_IDLE) ? job_in.idx[AW-1:0] : b_reg;
    assign row_addr = (state_reg == B_ACC) ? job_reg.idx[AW-1:0] : b_reg;
    assign row_full = vld_reg[row_addr] ? FULL_W'(rdata) : '0;
    assign we       = (state_reg == B_ACC);

    // Add each valid, non-saturated sample to its lane.
    always_comb
    begin
        new_full = row_full;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            lane_sum = row_full[c*LANE_W +: SUM_W];
            lane_cnt = row_full[c*LANE_W + SUM_W +: CNT_W];
            lane_t   = job_reg.temps[c];
            if ((c < CHANNELS) && (lane_t != SAMPLE_MISSING) && (lane_cnt != CNT_MAX))
            begin
                lane_sum = lane_sum + {{(SUM_W-16){lane_t[15]}}, lane_t};
                lane_cnt = lane_cnt + CNT_W'(1);
            end
            new_full[c*LANE_W +: SUM_W]         = lane_sum;
            new_full[c*LANE_W + SUM_W +: CNT_W] = lane_cnt;
        end
    end

    tbad_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BUCKETS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (row_addr),
        .wdata (new_full[RW-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Rounded average: (|sum| + cnt/2) / cnt, sign restored afterwards.
    assign mag          = sums_reg[ch_reg][SUM_W-1] ? (32'd0 - sums_reg[ch_reg]) : sums_reg[ch_reg];
    assign div_dividend = mag + {17'd0, cnts_reg[ch_reg][CNT_W-1:1]};
    assign div_divisor  = {16'd0, cnts_reg[ch_reg]};
    assign div_start    = (state_reg == B_EDST) && mask_reg[ch_reg];
    assign q16          = sums_reg[ch_reg][SUM_W-1] ? (16'd0 - div_q[15:0]) : div_q[15:0];

    tbad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_vld_reg || !out_stall;
    assign pop      = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        cur.btime = time_reg;
        cur.avg   = avg_reg;
        cur.mask  = mask_reg;
        cur.last  = 1'b0;
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        b_next        = b_reg;
        time_next     = time_reg;
        ch_next       = ch_reg;
        mask_next     = mask_reg;
        sums_next     = sums_reg;
        cnts_next     = cnts_reg;
        avg_next      = avg_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && out_stall;
        vld_next      = vld_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    job_next = job_in;
                    if (job_in.cmd)
                    begin
                        b_next     = '0;
                        time_next  = job_in.wstart;
                        state_next = B_ERD;
                    end
                    else
                    begin
                        state_next = B_ACC;
                    end
                end
            end
            B_ACC:
            begin
                vld_next[row_addr] = 1'b1;
                state_next         = B_IDLE;
            end
            B_ERD:
            begin
                state_next = B_EWT;
            end
            B_EWT:
            begin
                for (int c = 0; c < NUM_LANES; c++)
                begin
                    sums_next[c] = row_full[c*LANE_W +: SUM_W];
                    cnts_next[c] = row_full[c*LANE_W + SUM_W +: CNT_W];
                    mask_next[c] = (c < CHANNELS) &&
                                   (row_full[c*LANE_W + SUM_W +: CNT_W] != '0);
                end
                ch_next = '0;
                if (mask_next == '0)
                begin
                    if (b_reg == LAST_ROW)
                    begin
                        state_next = B_EEND;
                    end
                    else
                    begin
                        b_next     = b_reg + AW'(1);
                        time_next  = time_reg + job_reg.bwidth;
                        state_next = B_ERD;
                    end
                end
                else
                begin
                    state_next = B_EDST;
                end
            end
            B_EDST:
            begin
                if (mask_reg[ch_reg])
                begin
                    state_next = B_EDWT;
                end
                else
                begin
                    avg_next[ch_reg] = '0;
                    ch_next          = ch_reg + 2'd1;
                    if (ch_reg == 2'd3)
                    begin
                        state_next = B_EPUT;
                    end
                end
            end
            B_EDWT:
            begin
                if (div_done)
                begin
                    avg_next[ch_reg] = q16;
                    ch_next          = ch_reg + 2'd1;
                    state_next       = (ch_reg == 2'd3) ? B_EPUT : B_EDST;
                end
            end
            B_EPUT:
            begin
                // Hold one finished bucket back so that last can be set on it.
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next     = pend_reg;
                        out_vld_next = 1'b1;
                    end
                    pend_next     = cur;
                    pend_vld_next = 1'b1;
                    if (b_reg == LAST_ROW)
                    begin
                        state_next = B_EEND;
                    end
                    else
                    begin
                        b_next     = b_reg + AW'(1);
                        time_next  = time_reg + job_reg.bwidth;
                        state_next = B_ERD;
                    end
                end
            end
            B_EEND:
            begin
                if (out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next.btime = job_reg.wstart;
                        out_next.avg   = '0;
                        out_next.mask  = '0;
                        out_next.last  = 1'b1;
                    end
                    out_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    vld_next      = '0;
                    state_next    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            vld_reg      <= '0;
            ch_reg       <= '0;
            b_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            vld_reg      <= vld_next;
            ch_reg       <= ch_next;
            b_reg        <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        time_reg <= time_next;
        mask_reg <= mask_next;
        sums_reg <= sums_next;
        cnts_reg <= cnts_next;
        avg_reg  <= avg_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign res       = out_reg;

endmodule

FILE: hw/rtl/time_bucket_average_downsampler_unit.sv
// ============================================================================
// time_bucket_average_downsampler_unit: time bucket averaging downsampler
// Sorts timestamped four-channel temperature records into time buckets and,
// on an emit beat, streams one rounded-average beat per non-empty bucket.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  input   | in        | in_valid / in_stall | cmd, timestamp, temp_a..temp_d
//  output  | out       | out_valid/out_stall | bucket_time, avg_a..avg_d,
//          |           |                     | channel_mask, last
//  config  | in/out    | APB (pready tied 1) | range_seconds, max_points, now_time
//
// An accumulate beat takes two passes of the front's bit-serial divider
// (bucket width, then bucket index); the back then performs the
// read-modify-write of the bucket row, reading in B_IDLE and writing in B_ACC.
// An emit beat walks all MAX_BUCKETS rows, reading each row in B_ERD and B_EWT,
// running the back divider for every channel average that is produced and
// queueing each non-empty bucket in B_EPUT.
// Reset clears the row valid bits at once, so no clearing pass is needed and
// the block can accept a beat as soon as reset is released.
// A stalled output holds the back; the two-entry queue then lets the front
// keep classifying records until it fills.
//
module time_bucket_average_downsampler_unit #(
    parameter int CHANNELS    = 4,
    parameter int MAX_BUCKETS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // record input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [31:0]        timestamp,
    input  logic signed [15:0] temp_a,
    input  logic signed [15:0] temp_b,
    input  logic signed [15:0] temp_c,
    input  logic signed [15:0] temp_d,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        bucket_time,
    output logic signed [15:0] avg_a,
    output logic signed [15:0] avg_b,
    output logic signed [15:0] avg_c,
    output logic signed [15:0] avg_d,
    output logic [3:0]         channel_mask,
    output logic               last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import tbad_pkg::*;

    localparam logic [31:0] RANGE_RESET  = 32'd86400;
    localparam logic [5:0]  POINTS_RESET = 6'd48;
    localparam logic [31:0] NOW_RESET    = 32'd0;

    logic [31:0] range_reg, range_next;
    logic [5:0]  points_reg, points_next;
    logic [31:0] now_reg, now_next;
    logic        cfg_wr;

    temp_vec_t   temps;
    logic        q_push, q_full, q_pop, q_empty;
    job_t        front_job, back_job;
    res_t        res;

    // Configuration registers. A write lands in the access phase; the
    // register index is taken from the word address.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        range_next  = range_reg;
        points_next = points_reg;
        now_next    = now_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RANGE:  range_next  = pwdata;
                REG_POINTS: points_next = pwdata[5:0];
                REG_NOW:    now_next    = pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RANGE:  prdata = range_reg;
            REG_POINTS: prdata = {26'd0, points_reg};
            REG_NOW:    prdata = now_reg;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= RANGE_RESET;
            points_reg <= POINTS_RESET;
            now_reg    <= NOW_RESET;
        end
        else
        begin
            range_reg  <= range_next;
            points_reg <= points_next;
            now_reg    <= now_next;
        end
    end

    // Lane 0 carries channel a, lane 3 channel d.
    assign temps = {temp_d, temp_c, temp_b, temp_a};

    // The front turns each record into a job carrying its bucket index, or
    // drops it when it lies outside the window. Emit beats pass straight on
    // with the window start and bucket width they need for bucket times.
    tbad_front #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .timestamp     (timestamp),
        .temps         (temps),
        .range_seconds (range_reg),
        .max_points    (points_reg),
        .now_time      (now_reg),
        .push          (q_push),
        .job           (front_job),
        .q_full        (q_full)
    );

    tbad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (front_job),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (back_job),
        .empty   (q_empty)
    );

    // The back owns the bucket store and the output register.
    tbad_back #(
        .CHANNELS    (CHANNELS),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .job_in    (back_job),
        .pop       (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res)
    );

    assign bucket_time  = res.btime;
    assign avg_a        = $signed(res.avg[0]);
    assign avg_b        = $signed(res.avg[1]);
    assign avg_c        = $signed(res.avg[2]);
    assign avg_d        = $signed(res.avg[3]);
    assign channel_mask = res.mask;
    assign last         = res.last;

    // Only the closing beat of an emit run may carry an empty mask.
    a_empty_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (channel_mask != 4'd0) || last)
        else $error("empty bucket beat that is not the last one");

    // Channels that are not built never report a valid average.
    a_unused_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((channel_mask >> CHANNELS) == 4'd0))
        else $error("mask bit set for an unbuilt channel");

    // The front holds off the next beat while it classifies this one.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("front accepted two beats back to back");

endmodule

FILE: bench/time_bucket_average_downsampler_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// time_bucket_average_downsampler_unit_tb: self-checking bench of the downsampler
// A directed table of records, emits and register writes, then randomized
// windows filled with records under several idling patterns. Every result beat
// is compared with the bench's bucket averaging predictor or a typed-in beat.
// ============================================================================
module time_bucket_average_downsampler_unit_tb;
    import tbad_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    // An accumulate beat may still be in the front divider when the last
    // expected result arrives; this many quiet cycles covers it.
    localparam int SETTLE_CYCLES  = 120;
    localparam int NUM_BUCKETS    = 64;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    // One row of the directed table: either a register write or a record
    // beat, with an expected result typed in where it is obvious.
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_sel;
        logic [31:0] reg_value;
        logic        cmd;
        logic [31:0] ts;
        temp_vec_t   temps;
        bit          typed;
        res_t        typed_res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic [31:0]        timestamp;
    logic signed [15:0] temp_a;
    logic signed [15:0] temp_b;
    logic signed [15:0] temp_c;
    logic signed [15:0] temp_d;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        bucket_time;
    logic signed [15:0] avg_a;
    logic signed [15:0] avg_b;
    logic signed [15:0] avg_c;
    logic signed [15:0] avg_d;
    logic [3:0]         channel_mask;
    logic               last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    time_bucket_average_downsampler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .timestamp(timestamp),
        .temp_a(temp_a), .temp_b(temp_b), .temp_c(temp_c), .temp_d(temp_d),
        .out_valid(out_valid), .out_stall(out_stall), .bucket_time(bucket_time),
        .avg_a(avg_a), .avg_b(avg_b), .avg_c(avg_c), .avg_d(avg_d),
        .channel_mask(channel_mask), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the registers and the bucket store.
    logic [31:0] shadow_range;
    logic [5:0]  shadow_points;
    logic [31:0] shadow_now;
    int          lane_sum [NUM_BUCKETS*4];
    int unsigned lane_cnt [NUM_BUCKETS*4];

    // Results still owed by the block, oldest first.
    res_t        pending_buckets[$];
    row_t        directed_rows[$];

    int          error_count;
    int          idle_cycles;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Window start and bucket width follow the current registers.
    function automatic logic [31:0] window_base();
        return (shadow_range >= shadow_now) ? 32'd0 : shadow_now - shadow_range;
    endfunction

    function automatic logic [31:0] bucket_span();
        logic [31:0] divisor;
        logic [31:0] span;
        divisor = (shadow_points == 0) ? 32'd1 : {26'd0, shadow_points};
        span    = shadow_range / divisor;
        return (span == 0) ? 32'd1 : span;
    endfunction

    // Mean rounded half away from zero, folded to 16 bits.
    function automatic logic [15:0] rounded_mean(int sum, int unsigned cnt);
        logic [31:0] mag;
        logic [31:0] q;
        mag = (sum < 0) ? 32'd0 - sum : sum;
        q   = (mag + cnt / 2) / cnt;
        if (sum < 0)
            q = 32'd0 - q;
        return q[15:0];
    endfunction

    task automatic predict_beat(logic op, logic [31:0] ts, temp_vec_t temps);
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] idx;
        logic [31:0] limit;
        res_t        r;
        int          slot;
        int          produced;
        base     = window_base();
        span     = bucket_span();
        produced = 0;
        if (op == 1'b0)
        begin
            if (ts < base || ts > shadow_now)
                return;
            limit = (shadow_points == 0) ? 32'd1 : {26'd0, shadow_points};
            if (limit > NUM_BUCKETS - 1)
                limit = NUM_BUCKETS - 1;
            idx = (ts - base) / span;
            if (idx > limit)
                idx = limit;
            for (int ch = 0; ch < 4; ch++)
            begin
                slot = idx * 4 + ch;
                if (temps[ch] != SAMPLE_MISSING && lane_cnt[slot] < 65535)
                begin
                    lane_sum[slot] += $signed(temps[ch]);
                    lane_cnt[slot]++;
                end
            end
            return;
        end
        // Emit walks every bucket, whatever max_points is now.
        for (int b = 0; b < NUM_BUCKETS; b++)
        begin
            r       = '0;
            r.btime = base + b * span;
            for (int ch = 0; ch < 4; ch++)
            begin
                if (lane_cnt[b*4+ch] != 0)
                begin
                    r.mask[ch] = 1'b1;
                    r.avg[ch]  = rounded_mean(lane_sum[b*4+ch], lane_cnt[b*4+ch]);
                end
            end
            if (r.mask != 0)
            begin
                pending_buckets.push_back(r);
                produced++;
            end
        end
        if (produced == 0)
        begin
            r       = '0;
            r.btime = base;
            pending_buckets.push_back(r);
        end
        pending_buckets[pending_buckets.size()-1].last = 1'b1;
        for (int s = 0; s < NUM_BUCKETS*4; s++)
        begin
            lane_sum[s] = 0;
            lane_cnt[s] = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall at the falling edge, check at the rising edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_buckets.size() == 0)
            begin
                $display("%0t: unexpected result beat time=%h mask=%b", $time,
                         bucket_time, channel_mask);
                error_count++;
            end
            else
            begin
                want = pending_buckets.pop_front();
                if (want.btime !== bucket_time || want.avg[0] !== avg_a ||
                    want.avg[1] !== avg_b || want.avg[2] !== avg_c ||
                    want.avg[3] !== avg_d || want.mask !== channel_mask ||
                    want.last !== last)
                begin
                    $display("%0t: mismatch expected time=%h avg=%h %h %h %h mask=%b last=%b",
                             $time, want.btime, want.avg[0], want.avg[1], want.avg[2],
                             want.avg[3], want.mask, want.last);
                    $display("%0t:          actual   time=%h avg=%h %h %h %h mask=%b last=%b",
                             $time, bucket_time, avg_a, avg_b, avg_c, avg_d,
                             channel_mask, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("time_bucket_average_downsampler_unit_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------
    // Drive one record or emit beat; the sender may idle first. The beat is
    // predicted at the edge where the block takes it.
    task automatic send_beat(logic op, logic [31:0] ts, temp_vec_t temps,
                             bit typed, res_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd       = op;
        timestamp = ts;
        temp_a    = temps[0];
        temp_b    = temps[1];
        temp_c    = temps[2];
        temp_d    = temps[3];
        do
            @(posedge clk);
        while (in_stall);
        predict_beat(op, ts, temps);
        // A typed-in expectation replaces the single predicted beat.
        if (typed)
        begin
            void'(pending_buckets.pop_back());
            pending_buckets.push_back(typed_res);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every owed result is out and the front has gone quiet.
    task automatic drain();
        while (pending_buckets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write: a setup phase, then an access phase with pready high.
    task automatic write_reg(logic [1:0] sel, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (sel)
            REG_RANGE:  shadow_range  = value;
            REG_POINTS: shadow_points = value[5:0];
            REG_NOW:    shadow_now    = value;
            default:    ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic row_t item_row(logic op, logic [31:0] ts, logic [15:0] a,
                                      logic [15:0] b, logic [15:0] c, logic [15:0] d);
        row_t r;
        r          = '{kind: ROW_ITEM, default: '0};
        r.cmd      = op;
        r.ts       = ts;
        r.temps    = {d, c, b, a};
        return r;
    endfunction

    function automatic row_t cfg_row(logic [1:0] sel, logic [31:0] value);
        row_t r;
        r           = '{kind: ROW_CFG, default: '0};
        r.reg_sel   = sel;
        r.reg_value = value;
        return r;
    endfunction

    function automatic row_t emit_row_typed(logic [31:0] t, logic [15:0] a,
                                            logic [15:0] b, logic [15:0] c,
                                            logic [15:0] d, logic [3:0] mask);
        row_t r;
        r           = item_row(1'b1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        r.typed     = 1'b1;
        r.typed_res = '{btime: t, avg: {d, c, b, a}, mask: mask, last: 1'b1};
        return r;
    endfunction

    // A sample: mostly random, now and then invalid or at an extreme.
    function automatic logic [15:0] pick_temp();
        case ($urandom_range(9))
            0:       return SAMPLE_MISSING;
            1:       return 16'h7FFF;
            2:       return 16'h8001;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] base;
        logic [63:0] span;
        logic [31:0] ts;
        temp_vec_t   temps;
        res_t        none;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = 1'b0;
        timestamp     = '0;
        temp_a        = '0;
        temp_b        = '0;
        temp_c        = '0;
        temp_d        = '0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        none          = '0;
        shadow_range  = 32'd86400;
        shadow_points = 6'd48;
        shadow_now    = 32'd0;
        for (int s = 0; s < NUM_BUCKETS*4; s++)
        begin
            lane_sum[s] = 0;
            lane_cnt[s] = 0;
        end

        // With the reset registers the window is just second zero.
        // An emit with nothing stored gives one empty beat.
        directed_rows.push_back(emit_row_typed(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'b0000));
        directed_rows.push_back(item_row(1'b0, 32'd0, 16'h7FFF, SAMPLE_MISSING, 16'h8001,
                                         16'd0));
        directed_rows.push_back(item_row(1'b0, 32'd0, 16'd1, 16'hFFFF, 16'd100,
                                         SAMPLE_MISSING));
        // Above now_time, so it is skipped.
        directed_rows.push_back(item_row(1'b0, 32'd5, 16'd7, 16'd7, 16'd7, 16'd7));
        directed_rows.push_back(item_row(1'b0, 32'hFFFF_FFFF, 16'd7, 16'd7, 16'd7, 16'd7));
        // Halves round away from zero: 16384, -1, -16334, 0.
        directed_rows.push_back(emit_row_typed(32'd0, 16'd16384, 16'hFFFF, 16'hC032,
                                               16'd0, 4'b1111));
        // Narrow window 900..1000 with max_points 0, acting as max_points 1 with
        // width 100; the far end lands in index 1, the clamp limit.
        directed_rows.push_back(cfg_row(REG_RANGE, 32'd100));
        directed_rows.push_back(cfg_row(REG_POINTS, 32'd0));
        directed_rows.push_back(cfg_row(REG_NOW, 32'd1000));
        directed_rows.push_back(item_row(1'b0, 32'd899, 16'd5, 16'd5, 16'd5, 16'd5));
        directed_rows.push_back(item_row(1'b0, 32'd900, 16'd10, SAMPLE_MISSING, 16'hFFFB,
                                         16'd3));
        directed_rows.push_back(item_row(1'b0, 32'd950, 16'd11, SAMPLE_MISSING, 16'hFFFA,
                                         16'd4));
        directed_rows.push_back(item_row(1'b0, 32'd1000, 16'h8001, 16'h7FFF, 16'd0,
                                         SAMPLE_MISSING));
        directed_rows.push_back(item_row(1'b1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        // Widest window: range not below now, so the start is 0; top bucket index.
        directed_rows.push_back(cfg_row(REG_RANGE, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(REG_POINTS, 32'd63));
        directed_rows.push_back(cfg_row(REG_NOW, 32'hFFFF_FFFF));
        directed_rows.push_back(item_row(1'b0, 32'hFFFF_FFFF, 16'd1, 16'd2, 16'd3, 16'd4));
        directed_rows.push_back(item_row(1'b0, 32'd0, 16'hFFFF, 16'hFFFE, 16'd3,
                                         SAMPLE_MISSING));
        directed_rows.push_back(item_row(1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        // Zero range: width 1, the window is the single second now_time.
        directed_rows.push_back(cfg_row(REG_RANGE, 32'd0));
        directed_rows.push_back(item_row(1'b0, 32'hFFFF_FFFF, 16'd9, 16'd8, 16'd7, 16'd6));
        directed_rows.push_back(item_row(1'b0, 32'hFFFF_FFFE, 16'd9, 16'd8, 16'd7, 16'd6));
        directed_rows.push_back(item_row(1'b1, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with no idling on either side.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_value);
            end
            else
            begin
                send_beat(directed_rows[i].cmd, directed_rows[i].ts, directed_rows[i].temps,
                          directed_rows[i].typed, directed_rows[i].typed_res);
            end
        end

        // Random part: eight phases cycling through the idling patterns. Each
        // phase sets a fresh window, fills it with records and emits.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 78;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 78;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            drain();
            case ($urandom_range(3))
                0:       write_reg(REG_RANGE, $urandom);
                1:       write_reg(REG_RANGE, 32'hFFFF_FFFF);
                default: write_reg(REG_RANGE, $urandom_range(5000));
            endcase
            write_reg(REG_POINTS, ($urandom_range(4) == 0) ? 32'd63 : $urandom_range(63));
            write_reg(REG_NOW, ($urandom_range(5) == 0) ? 32'd0 : $urandom);
            base = window_base();
            span = {32'd0, shadow_now} - {32'd0, base} + 64'd1;
            for (int n = 0; n < 27; n++)
            begin
                for (int ch = 0; ch < 4; ch++)
                    temps[ch] = pick_temp();
                // Mostly in the window; the rest anywhere, often outside it.
                if ($urandom_range(99) < 85)
                    ts = base + 32'({$urandom, $urandom} % span);
                else
                    ts = $urandom;
                send_beat(1'b0, ts, temps, 1'b0, none);
                if ($urandom_range(9) == 0)
                    send_beat(1'b1, $urandom, temps, 1'b0, none);
            end
            send_beat(1'b1, $urandom, temps, 1'b0, none);
        end

        drain();
        if (error_count == 0)
            $display("time_bucket_average_downsampler_unit_tb: done, clean");
        else
            $display("time_bucket_average_downsampler_unit_tb: done, errors");
        $finish;
    end

endmodule
